// File: rtl/yrnd_pkg.sv
// ----------------------------------------------------------------------------
// yrnd_pkg
// Shared types, register codes and conversion constants for the YUV to RGB
// converter with nearest-neighbour downscaler.
// ----------------------------------------------------------------------------
package yrnd_pkg;

    // default sizing
    localparam int MAX_DIMENSION_DEF = 4096;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // register field widths
    localparam int DIM_W      = 13;
    localparam int POS_W      = 29;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 29;

    // colour arithmetic
    localparam int PIX_W        = 8;
    localparam int SUM_W        = 28;
    localparam int COLOUR_SHIFT = 16;

    localparam logic signed [SUM_W-1:0] K_RV_FULL = 28'sd91881;
    localparam logic signed [SUM_W-1:0] K_GU_FULL = 28'sd22554;
    localparam logic signed [SUM_W-1:0] K_GV_FULL = 28'sd46802;
    localparam logic signed [SUM_W-1:0] K_BU_FULL = 28'sd116130;
    localparam logic signed [SUM_W-1:0] K_Y_LTD   = 28'sd76284;
    localparam logic signed [SUM_W-1:0] K_RV_LTD  = 28'sd104595;
    localparam logic signed [SUM_W-1:0] K_GU_LTD  = 28'sd25624;
    localparam logic signed [SUM_W-1:0] K_GV_LTD  = 28'sd53281;
    localparam logic signed [SUM_W-1:0] K_BU_LTD  = 28'sd132251;
    localparam logic signed [SUM_W-1:0] CHROMA_OFS = 28'sd128;
    localparam logic signed [SUM_W-1:0] LUMA_OFS   = 28'sd16;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_WIDTH = 3'd0,
        REG_DEST_WIDTH   = 3'd1,
        REG_DEST_HEIGHT  = 3'd2,
        REG_COLUMN_STEP  = 3'd3,
        REG_ROW_STEP     = 3'd4,
        REG_FULL_RANGE   = 3'd5
    } cfg_index_t;

    // configuration bundle
    typedef struct packed {
        logic [DIM_W-1:0] source_width;
        logic [DIM_W-1:0] dest_width;
        logic [DIM_W-1:0] dest_height;
        logic [POS_W-1:0] column_step;
        logic [POS_W-1:0] row_step;
        logic             full_range;
    } cfg_t;

    // kept pixel as it travels from front to back
    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] chroma_red;
        logic             line_end;
        logic             frame_end;
    } pix_t;

endpackage

// File: rtl/yrnd_front.sv
// ----------------------------------------------------------------------------
// yrnd_front
// Tracks source and destination positions, picks the kept pixels and tags
// line and frame ends; kept pixels are pushed into the queue.
// ----------------------------------------------------------------------------
module yrnd_front #(
    parameter int MAX_DIMENSION = yrnd_pkg::MAX_DIMENSION_DEF,
    parameter int FRACTION_BITS = yrnd_pkg::FRACTION_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  yrnd_pkg::cfg_t              cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        frame_start,
    input  logic [yrnd_pkg::PIX_W-1:0]  luma,
    input  logic [yrnd_pkg::PIX_W-1:0]  chroma_blue,
    input  logic [yrnd_pkg::PIX_W-1:0]  chroma_red,
    input  logic                        full,
    output logic                        push,
    output yrnd_pkg::pix_t              entry
);
    import yrnd_pkg::*;

    localparam int COL_W = $clog2(MAX_DIMENSION);
    localparam int CMP_W = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;
    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1) << FRACTION_BITS;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // steps below one count as one
    function automatic logic [POS_W-1:0] step_of(input logic [POS_W-1:0] s);
        step_of = (s < POS_ONE) ? POS_ONE : s;
    endfunction

    // saturating position advance
    function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0] p,
                                                 input logic [POS_W-1:0] s);
        logic [POS_W:0] sum;
        sum = {1'b0, p} + {1'b0, s};
        advance = sum[POS_W] ? POS_MAX : sum[POS_W-1:0];
    endfunction

    logic [COL_W-1:0] src_col_reg, src_col_next, src_col_e;
    logic [COL_W-1:0] src_row_reg, src_row_next, src_row_e;
    logic [POS_W-1:0] ncol_pos_reg, ncol_pos_next, ncol_pos_e;
    logic [POS_W-1:0] nrow_pos_reg, nrow_pos_next, nrow_pos_e;
    logic [DIM_W-1:0] dst_col_reg, dst_col_next, dst_col_e;
    logic [DIM_W-1:0] dst_row_reg, dst_row_next, dst_row_e;
    logic             row_sel_reg, row_sel_next, row_sel_e;

    logic             accept;
    logic             emit;
    logic             line_wrap;
    logic [DIM_W-1:0] dst_col_inc;
    logic [DIM_W:0]   dst_row_inc;
    logic             le;
    logic             fe;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    // frame start clears the counters before this pixel is judged
    always_comb
    begin
        src_col_e  = frame_start ? '0 : src_col_reg;
        src_row_e  = frame_start ? '0 : src_row_reg;
        ncol_pos_e = frame_start ? '0 : ncol_pos_reg;
        nrow_pos_e = frame_start ? '0 : nrow_pos_reg;
        dst_col_e  = frame_start ? '0 : dst_col_reg;
        dst_row_e  = frame_start ? '0 : dst_row_reg;
        row_sel_e  = frame_start ? 1'b1 : row_sel_reg;
    end

    // keep decision and end flags
    always_comb
    begin
        emit = row_sel_e && (dst_row_e < cfg.dest_height)
            && (dst_col_e < cfg.dest_width)
            && (POS_W'(src_col_e) == (ncol_pos_e >> FRACTION_BITS));
        dst_col_inc = dst_col_e + DIM_W'(1);
        dst_row_inc = {1'b0, dst_row_e} + (DIM_W+1)'(1);
        le = (dst_col_inc == cfg.dest_width);
        fe = le && (dst_row_inc >= {1'b0, cfg.dest_height});
        line_wrap = ((CMP_W'(src_col_e) + CMP_W'(1)) >= CMP_W'(cfg.source_width))
            || ((CMP_W'(src_col_e) + CMP_W'(1)) >= CMP_W'(MAX_DIMENSION));
    end

    // next position state
    always_comb
    begin
        if (line_wrap)
        begin
            src_col_next  = '0;
            src_row_next  = (src_row_e < COL_W'(MAX_DIMENSION - 1))
                          ? src_row_e + COL_W'(1) : src_row_e;
            dst_row_next  = row_sel_e ? dst_row_inc[DIM_W-1:0] : dst_row_e;
            nrow_pos_next = row_sel_e ? advance(nrow_pos_e, step_of(cfg.row_step))
                                      : nrow_pos_e;
            dst_col_next  = '0;
            ncol_pos_next = '0;
            row_sel_next  = (dst_row_next < cfg.dest_height)
                && (POS_W'(src_row_next) == (nrow_pos_next >> FRACTION_BITS));
        end
        else
        begin
            src_col_next  = src_col_e + COL_W'(1);
            src_row_next  = src_row_e;
            dst_row_next  = dst_row_e;
            nrow_pos_next = nrow_pos_e;
            dst_col_next  = emit ? dst_col_inc : dst_col_e;
            ncol_pos_next = emit ? advance(ncol_pos_e, step_of(cfg.column_step))
                                 : ncol_pos_e;
            row_sel_next  = row_sel_e;
        end
    end

    // position registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg  <= '0;
            src_row_reg  <= '0;
            ncol_pos_reg <= '0;
            nrow_pos_reg <= '0;
            dst_col_reg  <= '0;
            dst_row_reg  <= '0;
            row_sel_reg  <= 1'b1;
        end
        else if (accept)
        begin
            src_col_reg  <= src_col_next;
            src_row_reg  <= src_row_next;
            ncol_pos_reg <= ncol_pos_next;
            nrow_pos_reg <= nrow_pos_next;
            dst_col_reg  <= dst_col_next;
            dst_row_reg  <= dst_row_next;
            row_sel_reg  <= row_sel_next;
        end
    end

    // queue write
    assign push              = accept && emit;
    assign entry.luma        = luma;
    assign entry.chroma_blue = chroma_blue;
    assign entry.chroma_red  = chroma_red;
    assign entry.line_end    = le;
    assign entry.frame_end   = fe;

    // frame end only ever marks the last pixel of a line
    a_fe_on_le: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!entry.frame_end || entry.line_end))
        else $error("frame end without line end");

endmodule

// File: rtl/yrnd_fifo.sv
// ----------------------------------------------------------------------------
// yrnd_fifo
// Short queue of kept pixels between the position front and the colour back.
// ----------------------------------------------------------------------------
module yrnd_fifo #(
    parameter int DEPTH = yrnd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  yrnd_pkg::pix_t wr_data,
    output logic           full,
    input  logic           pop,
    output logic           rd_valid,
    output yrnd_pkg::pix_t rd_data
);
    import yrnd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pix_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;
    assign rd_data  = mem[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count did not follow a push");

endmodule

// File: rtl/yrnd_back.sv
// ----------------------------------------------------------------------------
// yrnd_back
// BT.601 colour conversion of kept pixels: a product stage, then a sum,
// floor shift and saturate stage that feeds the output register.
// ----------------------------------------------------------------------------
module yrnd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        full_range,
    input  logic                        rd_valid,
    input  yrnd_pkg::pix_t              rd_data,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [yrnd_pkg::PIX_W-1:0]  red,
    output logic [yrnd_pkg::PIX_W-1:0]  green,
    output logic [yrnd_pkg::PIX_W-1:0]  blue,
    output logic                        line_end,
    output logic                        frame_end
);
    import yrnd_pkg::*;

    // clamp to 0..255
    function automatic logic [PIX_W-1:0] sat8(input logic signed [SUM_W-1:0] v);
        if (v < 0)
            sat8 = '0;
        else if (v > 255)
            sat8 = '1;
        else
            sat8 = v[PIX_W-1:0];
    endfunction

    logic                    s1_valid_reg;
    logic signed [SUM_W-1:0] t_r_reg, t_gu_reg, t_gv_reg, t_b_reg, c_reg;
    logic signed [SUM_W-1:0] y_reg;
    logic                    full_reg;
    logic                    le_reg;
    logic                    fe_reg;

    logic signed [SUM_W-1:0] y_ext, u_ext, v_ext;
    logic signed [SUM_W-1:0] t_r_next, t_gu_next, t_gv_next, t_b_next, c_next;
    logic signed [SUM_W-1:0] r_sum, g_prod, b_sum, g_sum;
    logic signed [SUM_W-1:0] r_val, g_val, b_val;

    logic                    out_valid_reg;
    logic [PIX_W-1:0]        red_reg, green_reg, blue_reg;
    logic                    le_out_reg, fe_out_reg;

    logic                    s2_ready;
    logic                    s1_ready;

    // stall chain
    assign s2_ready = !out_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign pop      = rd_valid && s1_ready;

    // stage 1: products
    always_comb
    begin
        y_ext = SUM_W'(rd_data.luma);
        u_ext = SUM_W'(rd_data.chroma_blue) - CHROMA_OFS;
        v_ext = SUM_W'(rd_data.chroma_red) - CHROMA_OFS;
        if (full_range)
        begin
            t_r_next  = K_RV_FULL * v_ext;
            t_gu_next = K_GU_FULL * u_ext;
            t_gv_next = K_GV_FULL * v_ext;
            t_b_next  = K_BU_FULL * u_ext;
            c_next    = y_ext <<< COLOUR_SHIFT;
        end
        else
        begin
            t_r_next  = K_RV_LTD * v_ext;
            t_gu_next = K_GU_LTD * u_ext;
            t_gv_next = K_GV_LTD * v_ext;
            t_b_next  = K_BU_LTD * u_ext;
            c_next    = K_Y_LTD * (y_ext - LUMA_OFS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= rd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            t_r_reg  <= t_r_next;
            t_gu_reg <= t_gu_next;
            t_gv_reg <= t_gv_next;
            t_b_reg  <= t_b_next;
            c_reg    <= c_next;
            y_reg    <= y_ext;
            full_reg <= full_range;
            le_reg   <= rd_data.line_end;
            fe_reg   <= rd_data.frame_end;
        end
    end

    // stage 2: sums and floor shift; full-range green subtracts a floored term
    always_comb
    begin
        r_sum  = c_reg + t_r_reg;
        b_sum  = c_reg + t_b_reg;
        g_prod = t_gu_reg + t_gv_reg;
        g_sum  = c_reg - g_prod;
        r_val  = r_sum >>> COLOUR_SHIFT;
        b_val  = b_sum >>> COLOUR_SHIFT;
        g_val  = full_reg ? (y_reg - (g_prod >>> COLOUR_SHIFT))
                          : (g_sum >>> COLOUR_SHIFT);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            red_reg    <= sat8(r_val);
            green_reg  <= sat8(g_val);
            blue_reg   <= sat8(b_val);
            le_out_reg <= le_reg;
            fe_out_reg <= fe_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign line_end  = le_out_reg;
    assign frame_end = fe_out_reg;

    // a product stage blocked by the output holds its pixel
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |=> (s1_valid_reg && $stable(c_reg)))
        else $error("stalled product stage lost its pixel");

endmodule

// File: rtl/yuv_to_rgb_nearest_downscale.sv
// ----------------------------------------------------------------------------
// yuv_to_rgb_nearest_downscale
// Nearest-neighbour downscaler followed by BT.601 YUV to RGB conversion.
// ----------------------------------------------------------------------------
// Source pixels enter on the in_valid / in_ready channel in raster order,
// frame_start marking the first pixel of a frame. Kept pixels leave on the
// out_valid / out_ready channel as saturated red, green and blue with
// line_end and frame_end flags; dropped pixels produce no transaction.
// Configuration is written through cfg_write / cfg_index / cfg_data; the
// user must write it only while the block is idle, which the block itself
// does not enforce; each write takes effect at its clock edge.
// Throughput: one source pixel per cycle while the queue is not full, set by
// the position update in the front; the colour back end is fully pipelined.
// A kept pixel goes through the queue, product stage and output register.
// Reset clears all position counters, selects row zero and loads the
// register defaults (4096 x 4096, unit steps, limited range).
// When the receiver stalls, the output register and product stage hold and
// the four-entry queue fills; in_ready drops only when the queue is full.
// ----------------------------------------------------------------------------
module yuv_to_rgb_nearest_downscale #(
    parameter int MAX_DIMENSION = yrnd_pkg::MAX_DIMENSION_DEF,
    parameter int FRACTION_BITS = yrnd_pkg::FRACTION_BITS_DEF,
    parameter int QUEUE_DEPTH   = yrnd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [yrnd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [yrnd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             frame_start,
    input  logic [yrnd_pkg::PIX_W-1:0]       luma,
    input  logic [yrnd_pkg::PIX_W-1:0]       chroma_blue,
    input  logic [yrnd_pkg::PIX_W-1:0]       chroma_red,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [yrnd_pkg::PIX_W-1:0]       red,
    output logic [yrnd_pkg::PIX_W-1:0]       green,
    output logic [yrnd_pkg::PIX_W-1:0]       blue,
    output logic                             line_end,
    output logic                             frame_end
);
    import yrnd_pkg::*;

    cfg_t cfg_reg;
    logic fifo_full;
    logic push;
    pix_t push_data;
    logic pop;
    logic rd_valid;
    pix_t rd_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_width <= DIM_W'(4096);
            cfg_reg.dest_width   <= DIM_W'(4096);
            cfg_reg.dest_height  <= DIM_W'(4096);
            cfg_reg.column_step  <= POS_W'(65536);
            cfg_reg.row_step     <= POS_W'(65536);
            cfg_reg.full_range   <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SOURCE_WIDTH: cfg_reg.source_width <= cfg_data[DIM_W-1:0];
                REG_DEST_WIDTH:   cfg_reg.dest_width   <= cfg_data[DIM_W-1:0];
                REG_DEST_HEIGHT:  cfg_reg.dest_height  <= cfg_data[DIM_W-1:0];
                REG_COLUMN_STEP:  cfg_reg.column_step  <= cfg_data[POS_W-1:0];
                REG_ROW_STEP:     cfg_reg.row_step     <= cfg_data[POS_W-1:0];
                REG_FULL_RANGE:   cfg_reg.full_range   <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // position tracking and pixel selection
    yrnd_front #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .frame_start (frame_start),
        .luma        (luma),
        .chroma_blue (chroma_blue),
        .chroma_red  (chroma_red),
        .full        (fifo_full),
        .push        (push),
        .entry       (push_data)
    );

    // decoupling queue
    yrnd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_data  (push_data),
        .full     (fifo_full),
        .pop      (pop),
        .rd_valid (rd_valid),
        .rd_data  (rd_data)
    );

    // colour conversion
    yrnd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .full_range (cfg_reg.full_range),
        .rd_valid   (rd_valid),
        .rd_data    (rd_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .line_end   (line_end),
        .frame_end  (frame_end)
    );

endmodule
